// ===== src/bsel_pkg.sv =====
package bsel_pkg;

	localparam int ACTION_W = 2;
	localparam int TARGET_W = 3;
	localparam int COUNT_FIELD_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 4;
	localparam int TIU_W = 4;
	localparam logic [TIU_W-1:0] TIU_RESET = 4'd3;

	typedef enum logic [ACTION_W-1:0] {
		ACT_SELECT  = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_HEALTH  = 2'd2,
		ACT_FAIL    = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POLICY  = 1'b0,
		REG_TARGETS = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		POLICY_RR = 1'b0,
		POLICY_LC = 1'b1
	} policy_t;

	typedef struct packed {
		action_t               action;
		logic [TARGET_W-1:0]   target_index;
		logic                  health_value;
	} item_t;

	typedef struct packed {
		logic                     granted;
		logic [TARGET_W-1:0]      chosen_target;
		logic [COUNT_FIELD_W-1:0] target_count;
		logic                     target_healthy;
	} result_t;

	// Control half of the beat that walks along the row of cells.
	typedef struct packed {
		logic                tok;
		action_t             action;
		logic [TARGET_W-1:0] target_index;
		logic                health_value;
		logic                hi_found;
		logic                lo_found;
		logic                lc_found;
		logic                hit;
		logic                hit_health;
	} ctl_t;

endpackage

// ===== src/bsel_cell.sv =====
module bsel_cell #(
	parameter int MAX_TARGETS = 8,
	parameter int COUNT_WIDTH = 16,
	parameter int CELL_ID = 0,
	localparam int PTR_W = $clog2(MAX_TARGETS),
	localparam int LIVE_W = $clog2(MAX_TARGETS + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [LIVE_W-1:0]      live,
	input  logic [PTR_W-1:0]       start_ptr,
	input  logic                   grant,
	input  logic [PTR_W-1:0]       grant_idx,
	input  bsel_pkg::ctl_t         prev_ctl,
	input  logic [PTR_W-1:0]       prev_hi_idx,
	input  logic [PTR_W-1:0]       prev_lo_idx,
	input  logic [PTR_W-1:0]       prev_lc_idx,
	input  logic [COUNT_WIDTH-1:0] prev_hi_cnt,
	input  logic [COUNT_WIDTH-1:0] prev_lo_cnt,
	input  logic [COUNT_WIDTH-1:0] prev_lc_cnt,
	input  logic [COUNT_WIDTH-1:0] prev_hit_cnt,
	output bsel_pkg::ctl_t         next_ctl,
	output logic [PTR_W-1:0]       next_hi_idx,
	output logic [PTR_W-1:0]       next_lo_idx,
	output logic [PTR_W-1:0]       next_lc_idx,
	output logic [COUNT_WIDTH-1:0] next_hi_cnt,
	output logic [COUNT_WIDTH-1:0] next_lo_cnt,
	output logic [COUNT_WIDTH-1:0] next_lc_cnt,
	output logic [COUNT_WIDTH-1:0] next_hit_cnt
);
	import bsel_pkg::*;

	localparam logic [PTR_W-1:0] MY_IDX = PTR_W'(CELL_ID);

	logic                   health_q;
	logic [COUNT_WIDTH-1:0] count_q;

	ctl_t                   ctl_d, ctl_q;
	logic [PTR_W-1:0]       hi_idx_d, lo_idx_d, lc_idx_d;
	logic [PTR_W-1:0]       hi_idx_q, lo_idx_q, lc_idx_q;
	logic [COUNT_WIDTH-1:0] hi_cnt_d, lo_cnt_d, lc_cnt_d, hit_cnt_d;
	logic [COUNT_WIDTH-1:0] hi_cnt_q, lo_cnt_q, lc_cnt_q, hit_cnt_q;
	logic                   upd;
	logic                   upd_health;
	logic [COUNT_WIDTH-1:0] upd_cnt;
	logic                   part;
	logic                   addressed;
	logic [COUNT_WIDTH-1:0] dec_cnt;

	assign part = CELL_ID < int'(live);
	assign addressed = int'(prev_ctl.target_index) == CELL_ID;
	assign dec_cnt = (count_q != '0) ? count_q - COUNT_WIDTH'(1) : count_q;

	always_comb begin
		ctl_d = prev_ctl;
		hi_idx_d = prev_hi_idx;
		lo_idx_d = prev_lo_idx;
		lc_idx_d = prev_lc_idx;
		hi_cnt_d = prev_hi_cnt;
		lo_cnt_d = prev_lo_cnt;
		lc_cnt_d = prev_lc_cnt;
		hit_cnt_d = prev_hit_cnt;
		upd = 1'b0;
		upd_health = health_q;
		upd_cnt = count_q;
		if (prev_ctl.tok) begin
			if (prev_ctl.action == ACT_SELECT) begin
				if (part && health_q) begin
					// First healthy target at or after the round-robin start.
					if (!prev_ctl.hi_found && CELL_ID >= int'(start_ptr)) begin
						ctl_d.hi_found = 1'b1;
						hi_idx_d = MY_IDX;
						hi_cnt_d = count_q;
					end
					// First healthy target overall, used when the scan wraps.
					if (!prev_ctl.lo_found) begin
						ctl_d.lo_found = 1'b1;
						lo_idx_d = MY_IDX;
						lo_cnt_d = count_q;
					end
					// Strict compare keeps the lowest index on a tie.
					if (!prev_ctl.lc_found || count_q < prev_lc_cnt) begin
						ctl_d.lc_found = 1'b1;
						lc_idx_d = MY_IDX;
						lc_cnt_d = count_q;
					end
				end
			end else if (addressed) begin
				upd = 1'b1;
				unique case (prev_ctl.action)
					ACT_HEALTH: begin
						upd_health = prev_ctl.health_value;
					end
					ACT_FAIL: begin
						upd_health = 1'b0;
						upd_cnt = dec_cnt;
					end
					ACT_RELEASE: begin
						upd_cnt = dec_cnt;
					end
					ACT_SELECT: begin
					end
				endcase
				ctl_d.hit = 1'b1;
				ctl_d.hit_health = upd_health;
				hit_cnt_d = upd_cnt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			health_q <= 1'b1;
			count_q <= '0;
		end else if (upd) begin
			health_q <= upd_health;
			count_q <= upd_cnt;
		end else if (grant && grant_idx == MY_IDX && count_q != '1) begin
			count_q <= count_q + COUNT_WIDTH'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		hi_idx_q <= hi_idx_d;
		lo_idx_q <= lo_idx_d;
		lc_idx_q <= lc_idx_d;
		hi_cnt_q <= hi_cnt_d;
		lo_cnt_q <= lo_cnt_d;
		lc_cnt_q <= lc_cnt_d;
		hit_cnt_q <= hit_cnt_d;
	end

	assign next_ctl = ctl_q;
	assign next_hi_idx = hi_idx_q;
	assign next_lo_idx = lo_idx_q;
	assign next_lc_idx = lc_idx_q;
	assign next_hi_cnt = hi_cnt_q;
	assign next_lo_cnt = lo_cnt_q;
	assign next_lc_cnt = lc_cnt_q;
	assign next_hit_cnt = hit_cnt_q;

endmodule

// ===== src/backend_selector_rr_least_conn.sv =====
// Backend target selector, round robin or least active connections.
// An item is taken at a rising edge with start high and busy low. Its beat
// then walks a row of MAX_TARGETS cells, one cell per cycle; each cell holds
// one target's health bit and connection count, applies release, health and
// fail items addressed to it, and folds its target into the running choice
// for a select. The end of the row grants the winner, whose count then rises.
// done is high for exactly one cycle, registered from the beat at the end of the
// row, with the result on result; the receiver cannot hold it off.
// busy stays high while the beat is in the row, so a new item is taken only
// once the beat has left the row of cells.
// Configuration writes (cfg_we, cfg_index, cfg_data) land at the next edge
// and are to be made only while the block is idle.
// Reset makes every target healthy with a count of zero, the round-robin
// pointer zero, the policy round robin and three targets in use.
module backend_selector_rr_least_conn #(
	parameter int MAX_TARGETS = 8,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  bsel_pkg::item_t                     item,
	output logic                                done,
	output bsel_pkg::result_t                   result,
	input  logic                                cfg_we,
	input  logic [bsel_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bsel_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import bsel_pkg::*;

	localparam int PTR_W = $clog2(MAX_TARGETS);
	localparam int LIVE_W = $clog2(MAX_TARGETS + 1);

	logic                   policy_q;
	logic [TIU_W-1:0]       tiu_q;
	logic [PTR_W-1:0]       rr_q;
	logic                   done_q;
	result_t                result_q;

	logic [LIVE_W-1:0]      live;
	logic [PTR_W-1:0]       start_ptr;
	logic                   accept;

	ctl_t                   chain_ctl [MAX_TARGETS+1];
	logic [PTR_W-1:0]       chain_hi_idx [MAX_TARGETS+1];
	logic [PTR_W-1:0]       chain_lo_idx [MAX_TARGETS+1];
	logic [PTR_W-1:0]       chain_lc_idx [MAX_TARGETS+1];
	logic [COUNT_WIDTH-1:0] chain_hi_cnt [MAX_TARGETS+1];
	logic [COUNT_WIDTH-1:0] chain_lo_cnt [MAX_TARGETS+1];
	logic [COUNT_WIDTH-1:0] chain_lc_cnt [MAX_TARGETS+1];
	logic [COUNT_WIDTH-1:0] chain_hit_cnt [MAX_TARGETS+1];

	ctl_t                   fin;
	logic                   found;
	logic [PTR_W-1:0]       widx;
	logic [COUNT_WIDTH-1:0] wcnt;
	logic [COUNT_WIDTH-1:0] wcnt_inc;
	logic                   grant;
	logic [COUNT_WIDTH-1:0] out_cnt;
	logic [PTR_W-1:0]       out_idx;
	logic [COUNT_FIELD_W+COUNT_WIDTH-1:0] cnt_wide;
	logic [TARGET_W+PTR_W-1:0]            idx_wide;
	logic                   busy_any;

	always_comb begin
		if (tiu_q == '0) begin
			live = LIVE_W'(1);
		end else if (int'(tiu_q) > MAX_TARGETS) begin
			live = LIVE_W'(MAX_TARGETS);
		end else begin
			live = LIVE_W'(tiu_q);
		end
	end

	assign start_ptr = (int'(rr_q) < int'(live)) ? rr_q : '0;
	assign accept = start && !busy;

	always_comb begin
		chain_ctl[0] = '0;
		chain_ctl[0].tok = accept;
		chain_ctl[0].action = item.action;
		chain_ctl[0].target_index = item.target_index;
		chain_ctl[0].health_value = item.health_value;
	end
	assign chain_hi_idx[0] = '0;
	assign chain_lo_idx[0] = '0;
	assign chain_lc_idx[0] = '0;
	assign chain_hi_cnt[0] = '0;
	assign chain_lo_cnt[0] = '0;
	assign chain_lc_cnt[0] = '0;
	assign chain_hit_cnt[0] = '0;

	for (genvar g = 0; g < MAX_TARGETS; g++) begin : g_cell
		bsel_cell #(
			.MAX_TARGETS(MAX_TARGETS),
			.COUNT_WIDTH(COUNT_WIDTH),
			.CELL_ID(g)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.live(live),
			.start_ptr(start_ptr),
			.grant(grant),
			.grant_idx(widx),
			.prev_ctl(chain_ctl[g]),
			.prev_hi_idx(chain_hi_idx[g]),
			.prev_lo_idx(chain_lo_idx[g]),
			.prev_lc_idx(chain_lc_idx[g]),
			.prev_hi_cnt(chain_hi_cnt[g]),
			.prev_lo_cnt(chain_lo_cnt[g]),
			.prev_lc_cnt(chain_lc_cnt[g]),
			.prev_hit_cnt(chain_hit_cnt[g]),
			.next_ctl(chain_ctl[g+1]),
			.next_hi_idx(chain_hi_idx[g+1]),
			.next_lo_idx(chain_lo_idx[g+1]),
			.next_lc_idx(chain_lc_idx[g+1]),
			.next_hi_cnt(chain_hi_cnt[g+1]),
			.next_lo_cnt(chain_lo_cnt[g+1]),
			.next_lc_cnt(chain_lc_cnt[g+1]),
			.next_hit_cnt(chain_hit_cnt[g+1])
		);
	end

	always_comb begin
		busy_any = 1'b0;
		for (int i = 1; i <= MAX_TARGETS; i++) begin
			busy_any = busy_any | chain_ctl[i].tok;
		end
	end
	assign busy = busy_any;

	assign fin = chain_ctl[MAX_TARGETS];

	always_comb begin
		if (policy_q == POLICY_LC) begin
			found = fin.lc_found;
			widx = chain_lc_idx[MAX_TARGETS];
			wcnt = chain_lc_cnt[MAX_TARGETS];
		end else if (fin.hi_found) begin
			found = 1'b1;
			widx = chain_hi_idx[MAX_TARGETS];
			wcnt = chain_hi_cnt[MAX_TARGETS];
		end else begin
			// Nothing healthy from the pointer onwards: wrap to the start.
			found = fin.lo_found;
			widx = chain_lo_idx[MAX_TARGETS];
			wcnt = chain_lo_cnt[MAX_TARGETS];
		end
	end

	assign wcnt_inc = (wcnt == '1) ? wcnt : wcnt + COUNT_WIDTH'(1);
	assign grant = fin.tok && fin.action == ACT_SELECT && found;

	always_comb begin
		if (fin.action == ACT_SELECT) begin
			out_cnt = found ? wcnt_inc : '0;
			out_idx = found ? widx : '0;
		end else begin
			out_cnt = fin.hit ? chain_hit_cnt[MAX_TARGETS] : '0;
			out_idx = '0;
		end
	end
	assign cnt_wide = {{COUNT_FIELD_W{1'b0}}, out_cnt};
	assign idx_wide = {{TARGET_W{1'b0}}, out_idx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POLICY_RR;
			tiu_q <= TIU_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POLICY: policy_q <= cfg_data[0];
				REG_TARGETS: tiu_q <= cfg_data[TIU_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rr_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= fin.tok;
			if (grant && policy_q == POLICY_RR) begin
				if (int'(widx) + 1 < int'(live)) begin
					rr_q <= widx + PTR_W'(1);
				end else begin
					rr_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin.tok) begin
			result_q.target_count <= cnt_wide[COUNT_FIELD_W-1:0];
			if (fin.action == ACT_SELECT) begin
				result_q.granted <= found;
				result_q.chosen_target <= idx_wide[TARGET_W-1:0];
				result_q.target_healthy <= found;
			end else begin
				result_q.granted <= 1'b0;
				result_q.chosen_target <= fin.target_index;
				result_q.target_healthy <= fin.hit && fin.hit_health;
			end
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule
